// ===== sv/sker_pkg.sv =====
// shared types, constants and command codes for the sorted key equal-range search
package sker_pkg;

  localparam int MAX_ROWS    = 1024;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int CNT_W       = $clog2(MAX_ROWS + 1);
  localparam int KEY_W       = 32;
  localparam int FIRST_ROW_W = 10;
  localparam int MATCH_W     = 11;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [KEY_W-1:0] key_value;
  } in_item_t;

  typedef struct packed {
    logic                   found;
    logic [FIRST_ROW_W-1:0] first_row;
    logic [MATCH_W-1:0]     match_count;
    logic                   overflow;
  } out_item_t;

  // bound search request from the command sequencer
  typedef struct packed {
    logic start;
    logic strict;
  } bnd_req_t;

  // bound search response back to the command sequencer
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] bound;
  } bnd_rsp_t;

endpackage

// ===== sv/sker_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
module sker_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/sker_bound.sv =====
// iterative bound search: one table read and one signed compare per step
module sker_bound import sker_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bnd_req_t                req,
  input  logic signed [KEY_W-1:0] key,
  input  logic [CNT_W-1:0]        row_count,
  output logic                    rd_en,
  output logic [ROW_W-1:0]        rd_addr,
  input  logic [KEY_W-1:0]        rd_data,
  output bnd_rsp_t                rsp
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] lo_r;
  logic [CNT_W-1:0] hi_r;
  logic [ROW_W-1:0] mid_r;
  logic             strict_r;
  logic             done_r;

  logic [CNT_W-1:0] span;
  logic [CNT_W-1:0] mid;
  logic             go_right;
  logic             more;

  always_comb begin
    span     = hi_r - lo_r;
    mid      = lo_r + (span >> 1);
    more     = (lo_r < hi_r);
    go_right = strict_r ? ($signed(rd_data) <= key) : ($signed(rd_data) < key);
  end

  assign rd_en   = (state_r == ST_READ) && more;
  assign rd_addr = mid[ROW_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      done_r   <= 1'b0;
      lo_r     <= '0;
      hi_r     <= '0;
      mid_r    <= '0;
      strict_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (req.start) begin
            lo_r     <= '0;
            hi_r     <= row_count;
            strict_r <= req.strict;
            state_r  <= ST_READ;
          end
        end
        ST_READ: begin
          if (more) begin
            mid_r   <= mid[ROW_W-1:0];
            state_r <= ST_CMP;
          end else begin
            done_r  <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        ST_CMP: begin
          if (go_right) begin
            lo_r <= CNT_W'(mid_r) + CNT_W'(1);
          end else begin
            hi_r <= CNT_W'(mid_r);
          end
          state_r <= ST_READ;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.bound = lo_r;

  // the probed row always lies inside the open window
  a_mid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> (CNT_W'(mid_r) >= lo_r) && (CNT_W'(mid_r) < hi_r))
    else $error("bound search probe outside window");

  // the window never inverts
  a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (lo_r <= hi_r))
    else $error("bound search window inverted");

  // completion reports a converged window
  a_done_converged: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (lo_r == hi_r) && (state_r == ST_IDLE))
    else $error("bound search finished without converging");

endmodule

// ===== sv/sorted_key_equal_range_search_top.sv =====
// top level of the sorted key table with equal-range query
//
//  channel  ports                          transfer when             width
//  in       start, busy, in_item           start && !busy            2 + 32
//  out      out_valid, out_item            out_valid (one cycle)     1 + 10 + 11 + 1
//
// clear and append finish in the cycle they are taken; busy stays low
// a query runs two bound searches back to back over the key ram; each step
// is one ram read plus one signed compare, in the states ST_READ and ST_CMP
// the result strobes on out_valid for one cycle and busy drops in that cycle
// rst_n is synchronous; it empties the table and clears the overflow flag
// the receiver cannot stall, so results never back up
module sorted_key_equal_range_search_top import sker_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOWER,
    ST_UPPER
  } state_t;

  state_t                  state_r;
  logic [CNT_W-1:0]        row_count_r;
  logic                    overflow_r;
  logic signed [KEY_W-1:0] key_r;
  logic [CNT_W-1:0]        lower_r;
  bnd_req_t                req_r;
  logic                    out_valid_r;
  out_item_t               out_item_r;

  // ram hookup
  logic                    ram_we;
  logic [ROW_W-1:0]        ram_waddr;
  logic                    ram_re;
  logic [ROW_W-1:0]        ram_raddr;
  logic [KEY_W-1:0]        ram_rdata;
  bnd_rsp_t                rsp;

  // decode of the accepted command
  logic                    accept;
  logic                    has_room;
  logic [CNT_W-1:0]        match_cnt;

  assign accept   = start && (state_r == ST_IDLE);
  assign has_room = (row_count_r < CNT_W'(MAX_ROWS));

  // appends go straight into the ram at the next free row
  assign ram_we    = accept && (in_item.cmd == CMD_APPEND) && has_room;
  assign ram_waddr = row_count_r[ROW_W-1:0];

  // run length is upper minus lower bound, zero if the bounds cross
  assign match_cnt = (rsp.bound > lower_r) ? (rsp.bound - lower_r) : '0;

  sker_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ROWS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_item.key_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sker_bound u_bound (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req_r),
    .key       (key_r),
    .row_count (row_count_r),
    .rd_en     (ram_re),
    .rd_addr   (ram_raddr),
    .rd_data   (ram_rdata),
    .rsp       (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_count_r <= '0;
      overflow_r  <= 1'b0;
      req_r       <= '0;
      out_valid_r <= 1'b0;
      key_r       <= '0;
      lower_r     <= '0;
      out_item_r  <= '0;
    end else begin
      req_r.start <= 1'b0;
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            unique case (in_item.cmd)
              CMD_CLEAR: begin
                // old keys stay in the ram but are out of reach
                row_count_r <= '0;
                overflow_r  <= 1'b0;
              end
              CMD_APPEND: begin
                if (has_room) begin
                  row_count_r <= row_count_r + CNT_W'(1);
                end else begin
                  overflow_r <= 1'b1;
                end
              end
              CMD_QUERY: begin
                // lower bound first: first row not less than the key
                key_r        <= in_item.key_value;
                req_r.start  <= 1'b1;
                req_r.strict <= 1'b0;
                state_r      <= ST_LOWER;
              end
              default: begin
                // unused command code, nothing happens
              end
            endcase
          end
        end
        ST_LOWER: begin
          if (rsp.done) begin
            // upper bound next: first row greater than the key
            lower_r      <= rsp.bound;
            req_r.start  <= 1'b1;
            req_r.strict <= 1'b1;
            state_r      <= ST_UPPER;
          end
        end
        ST_UPPER: begin
          if (rsp.done) begin
            out_valid_r            <= 1'b1;
            out_item_r.found       <= (match_cnt != '0);
            out_item_r.first_row   <= (match_cnt != '0) ? FIRST_ROW_W'(lower_r) : '0;
            out_item_r.match_count <= MATCH_W'(match_cnt);
            out_item_r.overflow    <= overflow_r;
            state_r                <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // the fill count never passes capacity
  a_row_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    row_count_r <= CNT_W'(MAX_ROWS))
    else $error("row count beyond capacity");

  // a reported run is never empty and an empty result starts at row zero
  a_found_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.found == (out_item.match_count != '0)) &&
                  (out_item.found || (out_item.first_row == '0)))
    else $error("found flag disagrees with run length");

  // a taken query holds the block busy on the following cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.cmd == CMD_QUERY)) |=> busy)
    else $error("query taken without going busy");

  // results come one per query, never on adjacent cycles
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

endmodule

// ===== sim/sorted_key_equal_range_search_tb.sv =====
// self-checking testbench for the sorted key table with equal-range query
module tb import sker_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // cmd 3 has no package name; the block must ignore it
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
  localparam int RANDOM_ITEMS = 550;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_GAP      = 13;

  // mirror of the key table; holds query results still to come
  class range_scoreboard;
    logic signed [KEY_W-1:0] keys [MAX_ROWS];
    int unsigned             rows;
    bit                      overflowed;
    out_item_t               pending [$];
    int                      errors;

    function new();
      rows       = 0;
      overflowed = 0;
      errors     = 0;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // first row whose key is not below k, or above k when strict
    function int unsigned bound_row(logic signed [KEY_W-1:0] k, bit strict);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = rows;
      while (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (strict ? (keys[mid] <= k) : (keys[mid] < k)) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    task note_transfer(in_item_t it);
      int unsigned lo;
      int unsigned hi;
      int unsigned run;
      out_item_t   want;
      case (it.cmd)
        CMD_CLEAR: begin
          rows       = 0;
          overflowed = 0;
        end
        CMD_APPEND: begin
          if (rows < MAX_ROWS) begin
            keys[rows] = it.key_value;
            rows++;
          end else begin
            overflowed = 1;
          end
        end
        CMD_QUERY: begin
          lo  = bound_row(it.key_value, 1'b0);
          hi  = bound_row(it.key_value, 1'b1);
          run = (hi > lo) ? hi - lo : 0;
          want.found       = (run != 0);
          want.first_row   = (run != 0) ? FIRST_ROW_W'(lo) : '0;
          want.match_count = MATCH_W'(run);
          want.overflow    = overflowed;
          pending.push_back(want);
        end
        default: ;
      endcase
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result %p with no query pending", got));
      end else begin
        want = pending.pop_front();
        if (got.found != want.found)
          report_mismatch($sformatf("found %0d, want %0d", got.found, want.found));
        if (got.first_row != want.first_row)
          report_mismatch($sformatf("first_row %0d, want %0d", got.first_row,
                                    want.first_row));
        if (got.match_count != want.match_count)
          report_mismatch($sformatf("match_count %0d, want %0d", got.match_count,
                                    want.match_count));
        if (got.overflow != want.overflow)
          report_mismatch($sformatf("overflow %0d, want %0d", got.overflow,
                                    want.overflow));
      end
    endtask
  endclass

  // all block inputs known from time zero
  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  range_scoreboard sb;
  int              loaded_keys [$];  // keys sent as appends since the last clear
  int              random_sent;      // counted transfers of the random part
  bit              quiet;            // phase without sender gaps

  sorted_key_equal_range_search_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // results live for one cycle; take each at the edge that ends it
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  // one command transfer: optional gap, then hold start until busy is low at an edge
  task automatic send_item(input logic [1:0] op, input logic signed [KEY_W-1:0] k);
    int       gap;
    in_item_t it;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    it.cmd       = op;
    it.key_value = k;
    start   <= 1'b1;
    in_item <= it;
    // busy read right after the edge is the value the block saw
    do @(posedge clk); while (busy);
    sb.note_transfer(it);
    if (op != CMD_UNUSED) random_sent++;
    if (op == CMD_CLEAR) loaded_keys.delete();
    else if (op == CMD_APPEND) loaded_keys.push_back(k);
    @(negedge clk);
  endtask

  // query key: mostly stored keys, some neighbors, extremes and noise
  function automatic logic signed [KEY_W-1:0] probe_key();
    int                      pick;
    logic signed [KEY_W-1:0] k;
    pick = $urandom_range(0, 9);
    if (loaded_keys.size() == 0 || pick == 9) begin
      k = $urandom;
    end else if (pick < 6) begin
      k = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
    end else if (pick < 8) begin
      k = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
      k = $urandom_range(0, 1) ? k + 1 : k - 1;
    end else begin
      case ($urandom_range(0, 2))
        0: k = KEY_MIN;
        1: k = KEY_MAX;
        default: k = '0;
      endcase
    end
    return k;
  endfunction

  // ascending keys with duplicate runs, narrow spread to get near misses
  task automatic sorted_keys(input int n, output int fresh [$]);
    bit narrow;
    int base;
    fresh.delete();
    narrow = $urandom_range(0, 1);
    base   = $urandom;
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 3) == 0) fresh.push_back(fresh[$urandom_range(0, i - 1)]);
      else if (narrow) fresh.push_back(base + int'($urandom_range(0, 2 * n + 2)));
      else fresh.push_back($urandom);
    end
    fresh.sort();
  endtask

  // well-formed sequence: clear, sorted appends, queries
  task automatic sorted_phase();
    int fresh [$];
    int n;
    n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 24);
    sorted_keys(n, fresh);
    // now and then build on top of the old table, order not kept
    if ($urandom_range(0, 5) != 0) send_item(CMD_CLEAR, $urandom);
    foreach (fresh[i]) send_item(CMD_APPEND, fresh[i]);
    repeat ($urandom_range(1, 12)) send_item(CMD_QUERY, probe_key());
  endtask

  // unordered appends, stray clears and the unused command
  task automatic noise_phase();
    int r;
    repeat ($urandom_range(4, 20)) begin
      r = $urandom_range(0, 9);
      if (r == 0) send_item(CMD_CLEAR, $urandom);
      else if (r < 5) send_item(CMD_APPEND, $urandom);
      else if (r < 8) send_item(CMD_QUERY, probe_key());
      else send_item(CMD_UNUSED, $urandom);
    end
  endtask

  // fill every row, overrun it, query, then clear the sticky flag
  task automatic full_table_phase(input bit one_key);
    int fresh [$];
    int k0;
    k0 = $urandom;
    if (one_key) begin
      fresh.delete();
      repeat (MAX_ROWS) fresh.push_back(k0);
    end else begin
      sorted_keys(MAX_ROWS, fresh);
    end
    send_item(CMD_CLEAR, $urandom);
    foreach (fresh[i]) send_item(CMD_APPEND, fresh[i]);
    // appends past capacity are dropped and set overflow
    repeat (3) send_item(CMD_APPEND, $urandom);
    send_item(CMD_QUERY, fresh[0]);
    send_item(CMD_QUERY, fresh[MAX_ROWS - 1]);
    send_item(CMD_QUERY, fresh[0] - 1);
    send_item(CMD_QUERY, fresh[MAX_ROWS - 1] + 1);
    repeat (8) send_item(CMD_QUERY, probe_key());
    send_item(CMD_UNUSED, k0);
    send_item(CMD_QUERY, k0);
    send_item(CMD_CLEAR, $urandom);
    send_item(CMD_QUERY, k0);
  endtask

  initial begin
    sb = new();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, key extremes, runs, misses, unordered keys
    quiet = 1'b0;
    send_item(CMD_QUERY,  KEY_MAX);       // empty table
    send_item(CMD_APPEND, KEY_MIN);
    send_item(CMD_APPEND, -32'sd1);
    send_item(CMD_APPEND, 32'sd0);
    send_item(CMD_APPEND, 32'sd0);
    send_item(CMD_APPEND, KEY_MAX);
    send_item(CMD_QUERY,  KEY_MIN);       // run at row 0
    send_item(CMD_QUERY,  32'sd0);        // run of two
    send_item(CMD_QUERY,  KEY_MAX);       // last row
    send_item(CMD_QUERY,  32'sd1);        // miss between keys
    send_item(CMD_QUERY,  -32'sd2);       // miss between keys
    send_item(CMD_UNUSED, 32'sd0);        // must change nothing
    send_item(CMD_QUERY,  32'sd0);
    send_item(CMD_APPEND, 32'sd5);        // order broken from here
    send_item(CMD_APPEND, 32'sd3);
    send_item(CMD_QUERY,  32'sd5);
    send_item(CMD_QUERY,  32'sd3);
    send_item(CMD_CLEAR,  KEY_MAX);
    send_item(CMD_QUERY,  32'sd0);        // empty again
    send_item(CMD_APPEND, 32'sd7);
    send_item(CMD_QUERY,  32'sd7);        // single row

    // full table twice: one long run, then many short ones
    quiet = 1'b0;
    full_table_phase(1'b1);
    quiet = ($urandom_range(0, 1) == 0);
    full_table_phase(1'b0);

    // random part, mostly well-formed sequences
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) noise_phase();
      else sorted_phase();
    end
    start <= 1'b0;

    // drain outstanding queries, then let a last search finish
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report_mismatch($sformatf("%0d results never came", sb.pending.size()));
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit, several times the slowest legal run
  initial begin
    #6_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sker_pkg.sv
sv/sker_ram.sv
sv/sker_bound.sv
sv/sorted_key_equal_range_search_top.sv
sim/sorted_key_equal_range_search_tb.sv
